>>> src/m3inv_pkg.sv
package m3inv_pkg;

   localparam int NumElems = 9;
   localparam int QuotBits = 32;
   localparam int DenBits  = 48;

   // adjugate entry k = a[ia]*a[ib] - a[ic]*a[id]
   localparam logic [3:0] IdxA [NumElems] = '{4'd4, 4'd2, 4'd1, 4'd5, 4'd0, 4'd2, 4'd3, 4'd1, 4'd0};
   localparam logic [3:0] IdxB [NumElems] = '{4'd8, 4'd7, 4'd5, 4'd6, 4'd8, 4'd3, 4'd7, 4'd6, 4'd4};
   localparam logic [3:0] IdxC [NumElems] = '{4'd5, 4'd1, 4'd2, 4'd3, 4'd2, 4'd0, 4'd4, 4'd0, 4'd1};
   localparam logic [3:0] IdxD [NumElems] = '{4'd7, 4'd8, 4'd4, 4'd8, 4'd6, 4'd5, 4'd6, 4'd7, 4'd3};

   typedef struct packed {
      logic                  neg;
      logic                  ovf;
      logic [DenBits-1:0]    prem;
      logic [QuotBits-1:0]   nq;
   } lane_type;

   typedef struct packed {
      logic                  singular;
      logic [DenBits-1:0]    den;
      lane_type [NumElems-1:0] lane;
   } div_type;

endpackage

>>> src/m3inv_div_cell.sv
module m3inv_div_cell (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  m3inv_pkg::div_type in_data,
   output logic              in_ready,
   output logic              out_valid,
   output m3inv_pkg::div_type out_data,
   input  logic              out_ready
);
   import m3inv_pkg::*;

   logic    valid_ff, valid_in;
   div_type data_ff, data_in;
   logic [DenBits:0] trial [NumElems];
   logic             ge [NumElems];

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   // one restoring division step per lane
   always_comb begin
      valid_in = in_ready ? in_valid : valid_ff;
      data_in  = in_data;
      for (int k = 0; k < NumElems; k++) begin
         trial[k] = {in_data.lane[k].prem, in_data.lane[k].nq[QuotBits-1]};
         ge[k]    = trial[k] >= {1'b0, in_data.den};
         data_in.lane[k].prem = ge[k] ? DenBits'(trial[k] - {1'b0, in_data.den})
                                      : trial[k][DenBits-1:0];
         data_in.lane[k].nq   = {in_data.lane[k].nq[QuotBits-2:0], ge[k]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

>>> src/m3inv_front.sv
module m3inv_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  logic [143:0]       in_data,
   output logic               in_ready,
   output logic               out_valid,
   output m3inv_pkg::div_type out_data,
   input  logic               out_ready
);
   import m3inv_pkg::*;

   localparam int Stages = 5;

   logic [Stages-1:0] vld_ff, vld_in;
   logic [Stages:0]   rdy;

   logic signed [15:0] a [NumElems];

   logic signed [31:0] p1_ff [NumElems], p1_in [NumElems];
   logic signed [31:0] p2_ff [NumElems], p2_in [NumElems];
   logic signed [15:0] row1_ff [3], row1_in [3];

   logic signed [32:0] adj2_ff [NumElems], adj2_in [NumElems];
   logic signed [15:0] row2_ff [3];

   logic signed [48:0] term_ff [3], term_in [3];
   logic signed [32:0] adj3_ff [NumElems];

   logic signed [49:0] det_ff, det_in;
   logic signed [32:0] adj4_ff [NumElems];

   div_type            res_ff, res_in;
   logic signed [49:0] det_mag;
   logic signed [32:0] adj_mag [NumElems];

   assign in_ready    = rdy[0];
   assign out_valid   = vld_ff[Stages-1];
   assign out_data    = res_ff;

   always_comb begin
      rdy[Stages] = out_ready;
      for (int s = Stages - 1; s >= 0; s--) begin
         rdy[s] = !vld_ff[s] || rdy[s+1];
      end
      vld_in[0] = rdy[0] ? in_valid : vld_ff[0];
      for (int s = 1; s < Stages; s++) begin
         vld_in[s] = rdy[s] ? vld_ff[s-1] : vld_ff[s];
      end
   end

   // cofactor products
   always_comb begin
      for (int k = 0; k < NumElems; k++) begin
         a[k] = signed'(in_data[16*k +: 16]);
      end
      for (int k = 0; k < NumElems; k++) begin
         p1_in[k] = a[IdxA[k]] * a[IdxB[k]];
         p2_in[k] = a[IdxC[k]] * a[IdxD[k]];
      end
      for (int j = 0; j < 3; j++) begin
         row1_in[j] = a[j];
      end
   end

   // adjugate
   always_comb begin
      for (int k = 0; k < NumElems; k++) begin
         adj2_in[k] = 33'(p1_ff[k]) - 33'(p2_ff[k]);
      end
   end

   // determinant terms along the first row
   always_comb begin
      term_in[0] = 49'(row2_ff[0]) * 49'(adj2_ff[0]);
      term_in[1] = 49'(row2_ff[1]) * 49'(adj2_ff[3]);
      term_in[2] = 49'(row2_ff[2]) * 49'(adj2_ff[6]);
   end

   always_comb begin
      det_in = 50'(term_ff[0]) + 50'(term_ff[1]) + 50'(term_ff[2]);
   end

   // magnitudes and divider setup
   always_comb begin
      det_mag         = det_ff[49] ? -det_ff : det_ff;
      res_in.singular = (det_ff == '0);
      res_in.den      = det_mag[DenBits-1:0];
      for (int k = 0; k < NumElems; k++) begin
         adj_mag[k]            = adj4_ff[k][32] ? -adj4_ff[k] : adj4_ff[k];
         res_in.lane[k].neg    = adj4_ff[k][32] ^ det_ff[49];
         res_in.lane[k].prem   = DenBits'(adj_mag[k][31:8]);
         res_in.lane[k].nq     = {adj_mag[k][7:0], 24'd0};
         res_in.lane[k].ovf    = DenBits'(adj_mag[k][31:8]) >= det_mag[DenBits-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
      if (rdy[0] && in_valid) begin
         p1_ff   <= p1_in;
         p2_ff   <= p2_in;
         row1_ff <= row1_in;
      end
      if (rdy[1] && vld_ff[0]) begin
         adj2_ff <= adj2_in;
         row2_ff <= row1_ff;
      end
      if (rdy[2] && vld_ff[1]) begin
         term_ff <= term_in;
         adj3_ff <= adj2_ff;
      end
      if (rdy[3] && vld_ff[2]) begin
         det_ff  <= det_in;
         adj4_ff <= adj3_ff;
      end
      if (rdy[4] && vld_ff[3]) begin
         res_ff <= res_in;
      end
   end

endmodule

>>> src/matrix3x3_inverse.sv
// pipeline: 38 register stages
// (5 setup stages, 32 division cells, 1 output register)
// throughput: one matrix per cycle unless stalled; one quotient bit per cell
// reset: synchronous, clears all stage valid bits; data registers are not reset
module matrix3x3_inverse (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [143:0] req_tdata,  // a00 a01 a02 a10 a11 a12 a20 a21 a22, 16 bits each
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [287:0] rsp_tdata,  // r00 r01 r02 r10 r11 r12 r20 r21 r22, 32 bits each
   output logic [1:0]   rsp_tuser   // singular, saturated
);
   import m3inv_pkg::*;

   logic    cv [QuotBits+1];
   logic    cr [QuotBits+1];
   div_type cd [QuotBits+1];

   logic         valid_ff, valid_in;
   logic [287:0] data_ff, data_in;
   logic [1:0]   user_ff, user_in;
   logic         out_ready;
   logic [QuotBits-1:0] q;
   logic         sat_any;

   m3inv_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_data   (req_tdata),
      .in_ready  (req_tready),
      .out_valid (cv[0]),
      .out_data  (cd[0]),
      .out_ready (cr[0])
   );

   for (genvar i = 0; i < QuotBits; i++) begin : g_cell
      m3inv_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (cv[i]),
         .in_data   (cd[i]),
         .in_ready  (cr[i]),
         .out_valid (cv[i+1]),
         .out_data  (cd[i+1]),
         .out_ready (cr[i+1])
      );
   end

   assign out_ready       = !valid_ff || rsp_tready;
   assign cr[QuotBits]    = out_ready;
   assign rsp_tvalid      = valid_ff;
   assign rsp_tdata       = data_ff;
   assign rsp_tuser       = user_ff;

   // sign, saturation and singular override
   always_comb begin
      valid_in = out_ready ? cv[QuotBits] : valid_ff;
      sat_any  = 1'b0;
      data_in  = '0;
      for (int k = 0; k < NumElems; k++) begin
         q = cd[QuotBits].lane[k].nq;
         if (cd[QuotBits].lane[k].neg) begin
            if (cd[QuotBits].lane[k].ovf || q > 32'h8000_0000) begin
               sat_any = 1'b1;
               data_in[32*k +: 32] = 32'h8000_0000;
            end else begin
               data_in[32*k +: 32] = -q;
            end
         end else begin
            if (cd[QuotBits].lane[k].ovf || q[31]) begin
               sat_any = 1'b1;
               data_in[32*k +: 32] = 32'h7fff_ffff;
            end else begin
               data_in[32*k +: 32] = q;
            end
         end
      end
      if (cd[QuotBits].singular) begin
         data_in = '0;
         user_in = 2'b01;
      end else begin
         user_in = {sat_any, 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (out_ready && cv[QuotBits]) begin
         data_ff <= data_in;
         user_ff <= user_in;
      end
   end

`ifndef SYNTHESIS
   a_singular_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata == '0 && !rsp_tuser[1])
      else $error("singular result carries data");

   a_reset_empty : assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");
`endif

endmodule
